@@ sv/oqrk_pkg.sv @@
// ============================================================================
// oqrk_pkg
// Shared sizes and codes for the ordered queue with remove by key.
// ============================================================================
package oqrk_pkg;

   // queue depth, legal range 2 to 64
   localparam int DEPTH    = 32;
   localparam int ADDR_W   = $clog2(DEPTH);
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int IDENT_W  = 32;
   localparam int MODE_W   = 2;
   localparam int STATUS_W = 3;

   // request modes
   localparam logic [MODE_W-1:0] MODE_ENQUEUE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_REMOVE  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_LIST    = 2'd2;

   // response status codes
   localparam logic [STATUS_W-1:0] ST_DONE     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd1;
   localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd2;
   localparam logic [STATUS_W-1:0] ST_ENTRY    = 3'd3;
   localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd4;

endpackage

@@ sv/ordered_queue_remove_by_key_unit.sv @@
// ============================================================================
// ordered_queue_remove_by_key_unit
// Arrival-ordered queue of identifiers with enqueue, remove-by-key and list.
// ============================================================================
// Usage:
//   A request word (req_mode, req_ident) is taken on a clock edge where start
//   is high and busy is low. Every request yields one or more response words,
//   each shown on rsp_* for exactly one cycle with rsp_valid high; rsp_last
//   marks the final word of a request. The receiver cannot stall: each word
//   is taken at the end of its cycle.
//   Enqueue, no-op, remove on an empty queue and list on an empty queue
//   answer in the cycle after acceptance and leave busy low, so one such
//   request can be taken every cycle.
//   Remove and list on a queue holding n entries sweep the slot memory once,
//   one read per cycle through its single read port; busy stays high, and no
//   new request is taken, until the last entry read has been handled. List
//   words come out one per cycle, head first. Remove compacts during the
//   same sweep by writing each later entry one slot lower. The sweep is
//   longest at the full depth of 32 entries.
//   Reset empties the queue at once; slot contents are not cleared since
//   only slots below the occupancy are ever read.
// ============================================================================
module ordered_queue_remove_by_key_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic        [oqrk_pkg::MODE_W-1:0]   req_mode,
   input  logic signed [oqrk_pkg::IDENT_W-1:0]  req_ident,
   output logic                                rsp_valid,
   output logic        [oqrk_pkg::STATUS_W-1:0] rsp_status,
   output logic signed [oqrk_pkg::IDENT_W-1:0]  rsp_entry,
   output logic                                rsp_last
);

   import oqrk_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_SWEEP
   } state_type;

   state_type                  state_ff, state_in;
   logic [MODE_W-1:0]          mode_ff, mode_in;
   logic [IDENT_W-1:0]         key_ff, key_in;
   logic [CNT_W-1:0]           occ_ff, occ_in;
   logic [CNT_W-1:0]           issue_ff, issue_in;
   logic                       pend_ff, pend_in;
   logic [ADDR_W-1:0]          pend_addr_ff, pend_addr_in;
   logic                       found_ff, found_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]        rsp_status_ff, rsp_status_in;
   logic [IDENT_W-1:0]         rsp_entry_ff, rsp_entry_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [IDENT_W-1:0]         wr_data;
   logic                       rd_en;
   logic [ADDR_W-1:0]          rd_addr;
   logic [IDENT_W-1:0]         rd_data;

   logic [ADDR_W-1:0]          last_addr;
   logic                       is_last;
   logic                       match;

   oqrk_ram #(
      .DATA_W (IDENT_W),
      .DEPTH  (DEPTH)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign last_addr = ADDR_W'(occ_ff - CNT_W'(1));
   assign is_last   = (pend_addr_ff == last_addr);
   assign match     = (rd_data == key_ff);

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      key_in        = key_ff;
      occ_in        = occ_ff;
      issue_in      = issue_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      found_in      = found_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = ST_DONE;
      rsp_entry_in  = '0;
      rsp_last_in   = 1'b1;
      wr_en         = 1'b0;
      wr_addr       = occ_ff[ADDR_W-1:0];
      wr_data       = req_ident;
      rd_en         = 1'b0;
      rd_addr       = issue_ff[ADDR_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in  = req_mode;
               key_in   = req_ident;
               issue_in = '0;
               found_in = 1'b0;
               case (req_mode)
                  MODE_ENQUEUE: begin
                     rsp_valid_in = 1'b1;
                     if (occ_ff == CNT_W'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        wr_en  = 1'b1;
                        occ_in = occ_ff + CNT_W'(1);
                     end
                  end
                  MODE_REMOVE: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_NOTFOUND;
                     end else begin
                        state_in = S_SWEEP;
                     end
                  end
                  MODE_LIST: begin
                     if (occ_ff == '0) begin
                        rsp_valid_in  = 1'b1;
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        state_in = S_SWEEP;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         S_SWEEP: begin
            // issue reads head to tail, one per cycle
            if (issue_ff < occ_ff) begin
               rd_en        = 1'b1;
               issue_in     = issue_ff + CNT_W'(1);
               pend_in      = 1'b1;
               pend_addr_in = issue_ff[ADDR_W-1:0];
            end
            if (pend_ff) begin
               if (mode_ff == MODE_LIST) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_ENTRY;
                  rsp_entry_in  = rd_data;
                  rsp_last_in   = is_last;
               end else begin
                  // after the match, move each word one slot toward the head
                  if (found_ff) begin
                     wr_en   = 1'b1;
                     wr_addr = pend_addr_ff - ADDR_W'(1);
                     wr_data = rd_data;
                  end else if (match) begin
                     found_in = 1'b1;
                  end
                  if (is_last) begin
                     rsp_valid_in = 1'b1;
                     if (found_ff || match) begin
                        occ_in = occ_ff - CNT_W'(1);
                     end else begin
                        rsp_status_in = ST_NOTFOUND;
                     end
                  end
               end
               if (is_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         occ_ff       <= '0;
         pend_ff      <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         pend_ff      <= pend_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      key_ff        <= key_in;
      issue_ff      <= issue_in;
      pend_addr_ff  <= pend_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_entry_ff  <= rsp_entry_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry  = rsp_entry_ff;
   assign rsp_last   = rsp_last_ff;

endmodule

@@ sv/oqrk_ram.sv @@
// ============================================================================
// oqrk_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ============================================================================
module oqrk_ram #(
   parameter int DATA_W = 32,
   parameter int DEPTH  = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ============================================================================
// tb
// Self-checking bench for the ordered queue with remove by key. Requests are
// fed from a queue with random gaps; the monitor keeps its own image of the
// queue, predicts every response word and checks each one in order.
// ============================================================================
module tb;
   import oqrk_pkg::*;

   localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;   // unused code, answers done
   localparam int QUIET_LIMIT = 2000;
   localparam int POOL_SIZE   = 16;

   typedef struct packed {
      logic        [MODE_W-1:0]  mode;
      logic signed [IDENT_W-1:0] ident;
   } request_type;

   typedef struct packed {
      logic        [STATUS_W-1:0] status;
      logic signed [IDENT_W-1:0]  entry;
      logic                       last;
   } rsp_word_type;

   logic                       clock;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic        [MODE_W-1:0]   req_mode = '0;
   logic signed [IDENT_W-1:0]  req_ident = '0;
   logic                       rsp_valid;
   logic        [STATUS_W-1:0] rsp_status;
   logic signed [IDENT_W-1:0]  rsp_entry;
   logic                       rsp_last;

   request_type  pending_requests[$];
   rsp_word_type expected_words[$];

   // predicted queue contents
   logic signed [IDENT_W-1:0] queue_image[DEPTH];
   int                        queue_fill = 0;

   int          error_count = 0;
   int          quiet_cycles = 0;
   int unsigned idle_left = 0;
   bit          calm_stretch = 1'b0;
   logic [IDENT_W-1:0] key_pool[POOL_SIZE];

   ordered_queue_remove_by_key_unit i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_mode   (req_mode),
      .req_ident  (req_ident),
      .rsp_valid  (rsp_valid),
      .rsp_status (rsp_status),
      .rsp_entry  (rsp_entry),
      .rsp_last   (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(string msg);
      if (error_count < 100)
         $display("%0t ns: mismatch: %s", $time, msg);
      error_count++;
   endtask

   function automatic void expect_word(logic [STATUS_W-1:0] status,
                                       logic signed [IDENT_W-1:0] entry, logic last);
      rsp_word_type w;
      w.status = status;
      w.entry  = entry;
      w.last   = last;
      expected_words.push_back(w);
   endfunction

   // update the queue image for one accepted request and queue its words
   function automatic void apply_request(logic [MODE_W-1:0] mode,
                                         logic signed [IDENT_W-1:0] key);
      int hit;
      hit = -1;
      case (mode)
         MODE_ENQUEUE: begin
            if (queue_fill >= DEPTH) begin
               expect_word(ST_FULL, '0, 1'b1);
            end else begin
               queue_image[queue_fill] = key;
               queue_fill++;
               expect_word(ST_DONE, '0, 1'b1);
            end
         end
         MODE_REMOVE: begin
            for (int i = 0; i < queue_fill && hit < 0; i++)
               if (queue_image[i] === key) hit = i;
            if (hit < 0) begin
               expect_word(ST_NOTFOUND, '0, 1'b1);
            end else begin
               for (int i = hit; i + 1 < queue_fill; i++)
                  queue_image[i] = queue_image[i + 1];
               queue_fill--;
               expect_word(ST_DONE, '0, 1'b1);
            end
         end
         MODE_LIST: begin
            if (queue_fill == 0)
               expect_word(ST_EMPTY, '0, 1'b1);
            else
               for (int i = 0; i < queue_fill; i++)
                  expect_word(ST_ENTRY, queue_image[i], i + 1 == queue_fill);
         end
         default: begin
            expect_word(ST_DONE, '0, 1'b1);
         end
      endcase
   endfunction

   // driver: start stays high until the word is taken
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         idle_left = 0;
      end else begin
         if (start && !busy) begin
            void'(pending_requests.pop_front());
            if ($urandom_range(0, 29) == 0) calm_stretch = ~calm_stretch;
            idle_left = calm_stretch ? 0 : $urandom_range(0, 6);
         end
         if (!(start && busy)) begin
            if (idle_left == 0 && pending_requests.size() > 0) begin
               start     <= 1'b1;
               req_mode  <= pending_requests[0].mode;
               req_ident <= pending_requests[0].ident;
            end else begin
               start <= 1'b0;
               if (idle_left > 0) idle_left--;
            end
         end
      end
   end

   // monitor: check responses first, then predict for a word taken this edge
   always @(posedge clock) begin
      rsp_word_type w;
      if (reset) begin
         queue_fill   = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("unexpected word status %0d entry %0d last %0d",
                                         rsp_status, rsp_entry, rsp_last));
            end else begin
               w = expected_words.pop_front();
               if (rsp_status !== w.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_status, w.status));
               if (rsp_entry !== w.entry)
                  report_mismatch($sformatf("entry %0d, expected %0d",
                                            rsp_entry, w.entry));
               if (rsp_last !== w.last)
                  report_mismatch($sformatf("last %0d, expected %0d",
                                            rsp_last, w.last));
            end
         end
         if (start && !busy)
            apply_request(req_mode, req_ident);
         if (rsp_valid || (start && !busy))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic void queue_request(logic [MODE_W-1:0] mode, logic [IDENT_W-1:0] key);
      request_type r;
      r.mode  = mode;
      r.ident = key;
      pending_requests.push_back(r);
   endfunction

   // pool keys give duplicates and remove hits
   function automatic logic [IDENT_W-1:0] pick_key();
      if ($urandom_range(0, 9) < 8)
         return key_pool[$urandom_range(0, POOL_SIZE - 1)];
      return $urandom;
   endfunction

   // weights in percent: enqueue, remove, list; rest is the unused code
   function automatic void queue_mixed(int enq_pct, int rem_pct, int list_pct);
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < enq_pct)
         queue_request(MODE_ENQUEUE, pick_key());
      else if (roll < enq_pct + rem_pct)
         queue_request(MODE_REMOVE, pick_key());
      else if (roll < enq_pct + rem_pct + list_pct)
         queue_request(MODE_LIST, $urandom);
      else
         queue_request(MODE_NOP, $urandom);
   endfunction

   initial begin
      int total;
      int span;

      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7fff_ffff;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hffff_ffff;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      // directed: empty cases, extremes, head/middle/tail removal, duplicates
      queue_request(MODE_LIST,    32'h0);
      queue_request(MODE_REMOVE,  32'h5);
      queue_request(MODE_NOP,     32'hffff_ffff);
      queue_request(MODE_ENQUEUE, 32'h8000_0000);
      queue_request(MODE_ENQUEUE, 32'h7fff_ffff);
      queue_request(MODE_ENQUEUE, 32'h0);
      queue_request(MODE_ENQUEUE, 32'hffff_ffff);
      queue_request(MODE_ENQUEUE, 32'h1234_5678);
      queue_request(MODE_LIST,    32'hffff_ffff);
      queue_request(MODE_REMOVE,  32'h9234_5678);   // differs in the top bit only
      queue_request(MODE_REMOVE,  32'h0);
      queue_request(MODE_REMOVE,  32'h8000_0000);
      queue_request(MODE_REMOVE,  32'h1234_5678);
      queue_request(MODE_LIST,    32'h0);
      queue_request(MODE_ENQUEUE, 32'h7fff_ffff);
      queue_request(MODE_REMOVE,  32'h7fff_ffff);   // first of two equal keys
      queue_request(MODE_LIST,    32'h0);
      queue_request(MODE_REMOVE,  32'hffff_ffff);
      queue_request(MODE_REMOVE,  32'h7fff_ffff);   // last entry, queue empties
      queue_request(MODE_LIST,    32'h0);
      queue_request(MODE_ENQUEUE, 32'h3);
      queue_request(MODE_LIST,    32'h0);
      queue_request(MODE_REMOVE,  32'h3);
      queue_request(MODE_NOP,     32'h8000_0000);

      total = pending_requests.size();
      while (total < 470) begin
         case ($urandom_range(0, 3))
            0: begin   // fill
               span = $urandom_range(20, 50);
               repeat (span) queue_mixed(70, 15, 10);
            end
            1: begin   // drain
               span = $urandom_range(20, 50);
               repeat (span) queue_mixed(15, 65, 15);
            end
            2: begin   // mixed
               span = $urandom_range(20, 50);
               repeat (span) queue_mixed(40, 35, 20);
            end
            default: begin   // saturate, then list a full queue
               span = $urandom_range(DEPTH + 2, DEPTH + 6);
               repeat (span) queue_request(MODE_ENQUEUE, pick_key());
               queue_request(MODE_LIST, $urandom);
               repeat (3) queue_request(MODE_REMOVE, pick_key());
               span = span + 4;
            end
         endcase
         total = total + span;
      end

      do @(posedge clock);
      while (pending_requests.size() != 0 || start || expected_words.size() != 0);
      repeat (DEPTH + 8) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

@@ filelist.f @@
sv/oqrk_pkg.sv
sv/oqrk_ram.sv
sv/ordered_queue_remove_by_key_unit.sv
tb/tb.sv
